>>> hdl/sorted_top_k_insert_defines.svh
// Assertion macros shared by the sorted top-k list.
// Each macro takes a label, the clock, the active-low reset and a property or condition.
`ifndef SORTED_TOP_K_INSERT_DEFINES_SVH
`define SORTED_TOP_K_INSERT_DEFINES_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define STK_ASSERT(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
		else $error("sorted_top_k_insert: assertion failed");

// The condition must never be true outside reset.
`define STK_ASSERT_NEVER(lbl, clk_s, rst_s, cond_s) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) !(cond_s)) \
		else $error("sorted_top_k_insert: forbidden condition seen");

`else

`define STK_ASSERT(lbl, clk_s, rst_s, prop)
`define STK_ASSERT_NEVER(lbl, clk_s, rst_s, cond_s)

`endif

`endif

>>> hdl/stk_pkg.sv
`timescale 1ns / 1ps

package stk_pkg;

	// list depth and field widths
	localparam int MAX_KEPT   = 16;
	localparam int DATA_W     = 32;
	localparam int KEEP_W     = 5;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = APB_ADDR_W - 2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_KEEP_COUNT = '0;

	localparam logic [KEEP_W-1:0] KEEP_COUNT_RESET = KEEP_W'(16);

	// one kept (distance, index) pair
	typedef struct packed {
		logic [DATA_W-1:0] distance;
		logic [DATA_W-1:0] idx;
	} entry_t;

	// controls broadcast to every cell of the chain
	typedef struct packed {
		logic   ins;
		logic   shift;
		entry_t cand;
	} ctl_t;

endpackage

>>> hdl/stk_if.sv
`timescale 1ns / 1ps

// candidate pair channel
interface stk_cand_if import stk_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] new_index;
	logic [DATA_W-1:0] new_distance;
	logic              end_of_set;

	modport source (output valid, new_index, new_distance, end_of_set, input ready);
	modport sink (input valid, new_index, new_distance, end_of_set, output ready);
endinterface

// sorted readout channel
interface stk_result_if import stk_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] out_index;
	logic [DATA_W-1:0] out_distance;
	logic              last_of_list;

	modport source (output valid, out_index, out_distance, last_of_list, input ready);
	modport sink (input valid, out_index, out_distance, last_of_list, output ready);
endinterface

>>> hdl/stk_cell.sv
`timescale 1ns / 1ps

// One slot of the sorted list. On an insert the slot loads the candidate,
// takes its lower neighbor's entry, or holds. On readout it takes the upper
// neighbor's entry so the list drains through slot zero.
module stk_cell import stk_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  ctl_t   ctl,
	input  logic   in_lim,
	input  logic   below_cond,
	input  logic   below_ev,
	input  entry_t below_ent,
	input  logic   above_valid,
	input  entry_t above_ent,
	output logic   cond,
	output logic   ev,
	output logic   valid,
	output entry_t ent
);

	logic   valid_q;
	entry_t ent_q;

	// slot counts only below the current limit
	assign ev = valid_q && in_lim;

	// candidate goes at or below this slot
	assign cond = !ev || (ent_q.distance > ctl.cand.distance);

	assign valid = valid_q;
	assign ent   = ent_q;

	// occupancy: grow by one up to the limit, or shift down on readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins) begin
			valid_q <= in_lim && (ev || below_ev);
		end else if (ctl.shift) begin
			valid_q <= above_valid;
		end
	end

	// payload: load candidate, shift up, or shift down
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (cond && !below_cond) begin
				ent_q <= ctl.cand;
			end else if (below_cond) begin
				ent_q <= below_ent;
			end
		end else if (ctl.shift) begin
			ent_q <= above_ent;
		end
	end

endmodule

>>> hdl/stk_cfg.sv
`timescale 1ns / 1ps

// APB register file: keep_count and the per-slot limit mask derived from it.
module stk_cfg import stk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [MAX_KEPT-1:0]   lim_mask
);

	logic [KEEP_W-1:0]    keep_count_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite;

	// write keep_count on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q <= KEEP_COUNT_RESET;
		end else if (wr_en && (reg_idx == REG_KEEP_COUNT)) begin
			keep_count_q <= pwdata[KEEP_W-1:0];
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_KEEP_COUNT) begin
			prdata = APB_DATA_W'(keep_count_q);
		end
	end

	// slot i is in use when i < keep_count; slot zero is always in use
	for (genvar g = 0; g < MAX_KEPT; g++) begin : g_mask
		assign lim_mask[g] = (g == 0) || (32'(keep_count_q) > 32'(g));
	end

endmodule

>>> hdl/sorted_top_k_insert.sv
`timescale 1ns / 1ps
// Sorted top-k list.
// Channel cand takes (new_index, new_distance, end_of_set) pairs. Each
// transfer is inserted into a chain of compare-and-shift slots kept in
// ascending distance order; ties keep arrival order, and entries beyond
// keep_count fall off the top. With no readout pending the block accepts
// one pair per cycle.
// A pair with end_of_set high is inserted, then the list drains through
// channel result, lowest distance first, starting the next cycle. Each
// result transfer shifts the chain down by one slot; last_of_list marks the
// final entry. cand.ready is low for the whole readout. A stall on result
// simply holds the chain and the offered entry.
// keep_count is written over APB at byte address 0 (reset value 16, 0 acts
// as 1, values above the depth act as the depth). The user must write it
// only while the block is idle; the block itself does not enforce this.
// Reset empties the list at once; there is no clearing pass.
`include "sorted_top_k_insert_defines.svh"

module sorted_top_k_insert import stk_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	stk_cand_if.sink              cand,
	stk_result_if.source          result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [MAX_KEPT-1:0] lim_mask;
	logic [MAX_KEPT-1:0] cond_vec;
	logic [MAX_KEPT-1:0] ev_vec;
	logic [MAX_KEPT-1:0] valid_vec;
	logic [MAX_KEPT-1:0] below_cond;
	logic [MAX_KEPT-1:0] below_ev;
	logic [MAX_KEPT-1:0] above_valid;
	entry_t              ent_vec   [MAX_KEPT];
	entry_t              below_ent [MAX_KEPT];
	entry_t              above_ent [MAX_KEPT];
	ctl_t                ctl;
	logic                drain_q;

	stk_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.lim_mask (lim_mask)
	);

	// broadcast controls
	assign cand.ready         = !drain_q;
	assign ctl.ins            = cand.valid && cand.ready;
	assign ctl.shift          = result.valid && result.ready;
	assign ctl.cand.distance  = cand.new_distance;
	assign ctl.cand.idx       = cand.new_index;

	// neighbor wiring: slot zero sees an always-full, never-greater floor
	for (genvar g = 0; g < MAX_KEPT; g++) begin : g_chain
		if (g == 0) begin : g_bot
			assign below_cond[g] = 1'b0;
			assign below_ev[g]   = 1'b1;
			assign below_ent[g]  = ctl.cand;
		end else begin : g_mid
			assign below_cond[g] = cond_vec[g-1];
			assign below_ev[g]   = ev_vec[g-1];
			assign below_ent[g]  = ent_vec[g-1];
		end
		if (g == MAX_KEPT - 1) begin : g_top
			assign above_valid[g] = 1'b0;
			assign above_ent[g]   = ent_vec[g];
		end else begin : g_low
			assign above_valid[g] = valid_vec[g+1];
			assign above_ent[g]   = ent_vec[g+1];
		end

		stk_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.in_lim      (lim_mask[g]),
			.below_cond  (below_cond[g]),
			.below_ev    (below_ev[g]),
			.below_ent   (below_ent[g]),
			.above_valid (above_valid[g]),
			.above_ent   (above_ent[g]),
			.cond        (cond_vec[g]),
			.ev          (ev_vec[g]),
			.valid       (valid_vec[g]),
			.ent         (ent_vec[g])
		);
	end

	// readout flag: set by an end-of-set transfer, drop after the last entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_q <= 1'b0;
		end else if (ctl.ins && cand.end_of_set) begin
			drain_q <= 1'b1;
		end else if (ctl.shift && !above_valid[0]) begin
			drain_q <= 1'b0;
		end
	end

	// result comes straight from slot zero
	assign result.valid        = drain_q;
	assign result.out_index    = ent_vec[0].idx;
	assign result.out_distance = ent_vec[0].distance;
	assign result.last_of_list = !above_valid[0];

	// checks
	`STK_ASSERT(a_drain_has_head, clk, arst_n, drain_q |-> valid_vec[0])
	`STK_ASSERT_NEVER(a_valid_prefix, clk, arst_n,
		((valid_vec + MAX_KEPT'(1)) & valid_vec) != '0)
	`STK_ASSERT(a_eos_starts_drain, clk, arst_n,
		(cand.valid && cand.ready && cand.end_of_set) |=> (drain_q && valid_vec[0]))
	`STK_ASSERT(a_last_ends_drain, clk, arst_n,
		(result.valid && result.ready && result.last_of_list) |=> (!drain_q && valid_vec == '0))

endmodule
